>>> hw/rtl/acn_pkg.sv
// acn_pkg: shared types, field widths and width helpers for the box contact pipeline.
// No dependencies; every module of the block imports it.
package acn_pkg;

   localparam int POS_W = 24;
   localparam int SIZE_W = 20;
   localparam int SCALE_W = 12;
   localparam int PROD_W = SIZE_W + SCALE_W;
   localparam int DEPTH_W = 25;
   localparam int THR_W = 8;

   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam logic [THR_W-1:0] MIN_OVERLAP_RESET = 8'd3;

   typedef struct packed {
      logic signed [POS_W-1:0] first_x;
      logic signed [POS_W-1:0] first_y;
      logic [SIZE_W-1:0] first_width;
      logic [SIZE_W-1:0] first_height;
      logic [SCALE_W-1:0] first_scale_x;
      logic [SCALE_W-1:0] first_scale_y;
      logic signed [POS_W-1:0] second_x;
      logic signed [POS_W-1:0] second_y;
      logic [SIZE_W-1:0] second_width;
      logic [SIZE_W-1:0] second_height;
      logic [SCALE_W-1:0] second_scale_x;
      logic [SCALE_W-1:0] second_scale_y;
   } req_type;

   typedef struct packed {
      logic contact;
      logic normal_axis;
      logic normal_negative;
      logic [DEPTH_W-1:0] penetration;
   } rsp_type;

   // width of a scaled size after dropping the fraction bits of the scale
   function automatic int scl_width(input int fb);
      return PROD_W - fb;
   endfunction

   // signed width of a far edge: position plus scaled size
   function automatic int edge_width(input int fb);
      int s;
      s = scl_width(fb) + 1;
      return ((s > POS_W) ? s : POS_W) + 1;
   endfunction

endpackage

>>> hw/rtl/aabb_contact_normal_top.sv
// aabb_contact_normal_top: box pair contact test, top level with the threshold register.
// Depends on acn_pkg, acn_scale, acn_edge, acn_resolve.
//
// Usage:
//   req channel: one word per box pair (positions, collider sizes, scales), valid/ready.
//   rsp channel: one word per pair: contact flag, normal axis and sign, penetration depth.
//   csr port: csr_wr_en writes csr_wr_data into the overlap threshold at the clock edge;
//     write it only while no pair is in flight.
// Pipeline: five register stages (scale multiply, far edges, side overlaps, overlap and
//   threshold tests, axis pick / output register). A word accepted on req passes through
//   them in that order and is then offered on rsp.
// Throughput: one pair per cycle while rsp_ready is high; every stage is a single pass
//   with no feedback, and takes a new word whenever it is empty or its successor moves.
// Reset: synchronous, clears all stage valid bits and sets the threshold to 3 (1/256 px).
// Stall: when rsp_ready is low the output word holds; the stages behind it keep filling
//   empty slots and req_ready drops only once every stage holds a word.
module aabb_contact_normal_top import acn_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCL_W = scl_width(FRACTION_BITS),
   localparam int DIFF_W = edge_width(FRACTION_BITS) + 1
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   logic [THR_W-1:0] min_overlap_ff, min_overlap_in;

   logic s_valid, s_ready;
   logic signed [POS_W-1:0] ax, ay, bx, by;
   logic [SCL_W-1:0] aw, ah, bw, bh;

   logic d_valid, d_ready;
   logic signed [DIFF_W-1:0] o_left, o_right, o_top, o_bottom;
   logic [SCL_W-1:0] d_aw, d_ah, d_bw, d_bh;

   assign min_overlap_in = csr_wr_en ? csr_wr_data : min_overlap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_overlap_ff <= MIN_OVERLAP_RESET;
      end else begin
         min_overlap_ff <= min_overlap_in;
      end
   end

   acn_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .in_data(req_data),
      .out_valid(s_valid),
      .out_ready(s_ready),
      .ax(ax),
      .ay(ay),
      .bx(bx),
      .by(by),
      .aw(aw),
      .ah(ah),
      .bw(bw),
      .bh(bh)
   );

   acn_edge #(.FRACTION_BITS(FRACTION_BITS)) u_edge (
      .clock(clock),
      .reset(reset),
      .in_valid(s_valid),
      .in_ready(s_ready),
      .ax(ax),
      .ay(ay),
      .bx(bx),
      .by(by),
      .aw(aw),
      .ah(ah),
      .bw(bw),
      .bh(bh),
      .out_valid(d_valid),
      .out_ready(d_ready),
      .o_left(o_left),
      .o_right(o_right),
      .o_top(o_top),
      .o_bottom(o_bottom),
      .aw_out(d_aw),
      .ah_out(d_ah),
      .bw_out(d_bw),
      .bh_out(d_bh)
   );

   acn_resolve #(.FRACTION_BITS(FRACTION_BITS)) u_resolve (
      .clock(clock),
      .reset(reset),
      .in_valid(d_valid),
      .in_ready(d_ready),
      .o_left(o_left),
      .o_right(o_right),
      .o_top(o_top),
      .o_bottom(o_bottom),
      .aw(d_aw),
      .ah(d_ah),
      .bw(d_bw),
      .bh(d_bh),
      .min_overlap(min_overlap_ff),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data(rsp_data)
   );

endmodule

>>> hw/rtl/acn_scale.sv
// acn_scale: first pipeline stage, scales the four collider sizes (one multiplier each).
// Depends on acn_pkg.
module acn_scale import acn_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCL_W = scl_width(FRACTION_BITS)
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  req_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [POS_W-1:0] ax,
   output logic signed [POS_W-1:0] ay,
   output logic signed [POS_W-1:0] bx,
   output logic signed [POS_W-1:0] by,
   output logic [SCL_W-1:0] aw,
   output logic [SCL_W-1:0] ah,
   output logic [SCL_W-1:0] bw,
   output logic [SCL_W-1:0] bh
);

   logic valid_ff;
   logic advance;
   logic [PROD_W-1:0] aw_prod, ah_prod, bw_prod, bh_prod;
   logic signed [POS_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [SCL_W-1:0] aw_ff, ah_ff, bw_ff, bh_ff;

   assign advance = !valid_ff || out_ready;
   assign in_ready = advance;

   assign aw_prod = PROD_W'(in_data.first_width) * PROD_W'(in_data.first_scale_x);
   assign ah_prod = PROD_W'(in_data.first_height) * PROD_W'(in_data.first_scale_y);
   assign bw_prod = PROD_W'(in_data.second_width) * PROD_W'(in_data.second_scale_x);
   assign bh_prod = PROD_W'(in_data.second_height) * PROD_W'(in_data.second_scale_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         ax_ff <= in_data.first_x;
         ay_ff <= in_data.first_y;
         bx_ff <= in_data.second_x;
         by_ff <= in_data.second_y;
         aw_ff <= aw_prod[PROD_W-1:FRACTION_BITS];
         ah_ff <= ah_prod[PROD_W-1:FRACTION_BITS];
         bw_ff <= bw_prod[PROD_W-1:FRACTION_BITS];
         bh_ff <= bh_prod[PROD_W-1:FRACTION_BITS];
      end
   end

   assign out_valid = valid_ff;
   assign ax = ax_ff;
   assign ay = ay_ff;
   assign bx = bx_ff;
   assign by = by_ff;
   assign aw = aw_ff;
   assign ah = ah_ff;
   assign bw = bw_ff;
   assign bh = bh_ff;

endmodule

>>> hw/rtl/acn_edge.sv
// acn_edge: second and third pipeline stages, far edges and the four side overlaps.
// Depends on acn_pkg.
module acn_edge import acn_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCL_W = scl_width(FRACTION_BITS),
   localparam int EDGE_W = edge_width(FRACTION_BITS),
   localparam int DIFF_W = EDGE_W + 1
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [POS_W-1:0] ax,
   input  logic signed [POS_W-1:0] ay,
   input  logic signed [POS_W-1:0] bx,
   input  logic signed [POS_W-1:0] by,
   input  logic [SCL_W-1:0] aw,
   input  logic [SCL_W-1:0] ah,
   input  logic [SCL_W-1:0] bw,
   input  logic [SCL_W-1:0] bh,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [DIFF_W-1:0] o_left,
   output logic signed [DIFF_W-1:0] o_right,
   output logic signed [DIFF_W-1:0] o_top,
   output logic signed [DIFF_W-1:0] o_bottom,
   output logic [SCL_W-1:0] aw_out,
   output logic [SCL_W-1:0] ah_out,
   output logic [SCL_W-1:0] bw_out,
   output logic [SCL_W-1:0] bh_out
);

   // stage 2: far edges
   logic e_valid_ff, e_advance;
   logic signed [EDGE_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [EDGE_W-1:0] ar_ff, ab_ff, br_ff, bb_ff;
   logic [SCL_W-1:0] e_aw_ff, e_ah_ff, e_bw_ff, e_bh_ff;
   logic signed [EDGE_W-1:0] ax_ext, ay_ext, bx_ext, by_ext;

   // stage 3: side overlaps
   logic d_valid_ff, d_advance;
   logic signed [DIFF_W-1:0] o_left_ff, o_right_ff, o_top_ff, o_bottom_ff;
   logic [SCL_W-1:0] d_aw_ff, d_ah_ff, d_bw_ff, d_bh_ff;

   assign d_advance = !d_valid_ff || out_ready;
   assign e_advance = !e_valid_ff || d_advance;
   assign in_ready = e_advance;

   assign ax_ext = EDGE_W'(ax);
   assign ay_ext = EDGE_W'(ay);
   assign bx_ext = EDGE_W'(bx);
   assign by_ext = EDGE_W'(by);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (e_advance) begin
            e_valid_ff <= in_valid;
         end
         if (d_advance) begin
            d_valid_ff <= e_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_advance && in_valid) begin
         ax_ff <= ax_ext;
         ay_ff <= ay_ext;
         bx_ff <= bx_ext;
         by_ff <= by_ext;
         ar_ff <= ax_ext + signed'(EDGE_W'(aw));
         ab_ff <= ay_ext + signed'(EDGE_W'(ah));
         br_ff <= bx_ext + signed'(EDGE_W'(bw));
         bb_ff <= by_ext + signed'(EDGE_W'(bh));
         e_aw_ff <= aw;
         e_ah_ff <= ah;
         e_bw_ff <= bw;
         e_bh_ff <= bh;
      end
   end

   always_ff @(posedge clock) begin
      if (d_advance && e_valid_ff) begin
         o_left_ff <= DIFF_W'(ar_ff) - DIFF_W'(bx_ff);
         o_right_ff <= DIFF_W'(br_ff) - DIFF_W'(ax_ff);
         o_top_ff <= DIFF_W'(ab_ff) - DIFF_W'(by_ff);
         o_bottom_ff <= DIFF_W'(bb_ff) - DIFF_W'(ay_ff);
         d_aw_ff <= e_aw_ff;
         d_ah_ff <= e_ah_ff;
         d_bw_ff <= e_bw_ff;
         d_bh_ff <= e_bh_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign o_left = o_left_ff;
   assign o_right = o_right_ff;
   assign o_top = o_top_ff;
   assign o_bottom = o_bottom_ff;
   assign aw_out = d_aw_ff;
   assign ah_out = d_ah_ff;
   assign bw_out = d_bw_ff;
   assign bh_out = d_bh_ff;

   a_edge_hold: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && !out_ready |=> d_valid_ff && $stable(o_left_ff) && $stable(o_top_ff))
      else $error("overlap stage changed while stalled");

endmodule

>>> hw/rtl/acn_resolve.sv
// acn_resolve: fourth and fifth pipeline stages, overlap and threshold tests, axis pick,
// output register. Depends on acn_pkg.
module acn_resolve import acn_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int SCL_W = scl_width(FRACTION_BITS),
   localparam int DIFF_W = edge_width(FRACTION_BITS) + 1
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [DIFF_W-1:0] o_left,
   input  logic signed [DIFF_W-1:0] o_right,
   input  logic signed [DIFF_W-1:0] o_top,
   input  logic signed [DIFF_W-1:0] o_bottom,
   input  logic [SCL_W-1:0] aw,
   input  logic [SCL_W-1:0] ah,
   input  logic [SCL_W-1:0] bw,
   input  logic [SCL_W-1:0] bh,
   input  logic [THR_W-1:0] min_overlap,
   output logic out_valid,
   input  logic out_ready,
   output rsp_type out_data
);

   // stage 4
   logic t_valid_ff, t_advance;
   logic hit_ff, thin_ff, left_lt_ff, top_lt_ff;
   logic signed [DIFF_W-1:0] min_x_ff, min_y_ff;
   logic hit_in, thin_in, left_lt_in, top_lt_in;
   logic signed [DIFF_W-1:0] thr_d;
   logic [SCL_W-1:0] thr_s;

   // stage 5
   logic r_valid_ff, r_advance;
   rsp_type rsp_ff, rsp_in;
   logic x_wins;
   logic signed [DIFF_W-1:0] depth;

   function automatic logic is_pos(input logic signed [DIFF_W-1:0] v);
      return !v[DIFF_W-1] && (v != '0);
   endfunction

   assign r_advance = !r_valid_ff || out_ready;
   assign t_advance = !t_valid_ff || r_advance;
   assign in_ready = t_advance;

   assign thr_d = signed'(DIFF_W'(min_overlap));
   assign thr_s = SCL_W'(min_overlap);

   // strict overlap on an axis needs both sizes nonzero and both cross overlaps positive;
   // the overlap extent is the lesser of the two cross overlaps
   always_comb begin
      hit_in = (aw != '0) && (bw != '0) && (ah != '0) && (bh != '0)
         && is_pos(o_left) && is_pos(o_right) && is_pos(o_top) && is_pos(o_bottom);
      thin_in = ((aw < thr_s) || (bw < thr_s) || (o_left < thr_d) || (o_right < thr_d))
         && ((ah < thr_s) || (bh < thr_s) || (o_top < thr_d) || (o_bottom < thr_d));
      left_lt_in = o_left < o_right;
      top_lt_in = o_top < o_bottom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (t_advance) begin
            t_valid_ff <= in_valid;
         end
         if (r_advance) begin
            r_valid_ff <= t_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (t_advance && in_valid) begin
         hit_ff <= hit_in;
         thin_ff <= thin_in;
         left_lt_ff <= left_lt_in;
         top_lt_ff <= top_lt_in;
         min_x_ff <= left_lt_in ? o_left : o_right;
         min_y_ff <= top_lt_in ? o_top : o_bottom;
      end
   end

   // tie between axes goes to vertical
   always_comb begin
      x_wins = min_x_ff < min_y_ff;
      depth = x_wins ? min_x_ff : min_y_ff;
      rsp_in = '0;
      if (hit_ff && !thin_ff) begin
         rsp_in.contact = 1'b1;
         rsp_in.normal_axis = !x_wins;
         rsp_in.normal_negative = x_wins ? left_lt_ff : top_lt_ff;
         rsp_in.penetration = depth[DIFF_W-1] ? '0 : depth[DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (r_advance && t_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = r_valid_ff;
   assign out_data = rsp_ff;

   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff && !rsp_ff.contact |-> !rsp_ff.normal_axis && !rsp_ff.normal_negative
         && (rsp_ff.penetration == '0))
      else $error("result without contact carries nonzero fields");

   a_hit_positive: assert property (@(posedge clock) disable iff (reset)
      t_valid_ff && hit_ff |-> is_pos(min_x_ff) && is_pos(min_y_ff))
      else $error("overlapping boxes with nonpositive side overlap");

   a_contact_follows: assert property (@(posedge clock) disable iff (reset)
      t_valid_ff && r_advance && hit_ff && !thin_ff |=> r_valid_ff && rsp_ff.contact)
      else $error("accepted overlap lost its contact flag");

endmodule
